// ===== hw/rtl/cspw_pkg.sv =====
`timescale 1ns / 1ps

package cspw_pkg;

  // glyph rows are always this many pixels wide
  localparam int GLYPH_W = 8;
  localparam int GLYPH_IW = $clog2(GLYPH_W);

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // register indexes on the configuration port
  localparam logic [2:0] REG_ENABLED   = 3'd0;
  localparam logic [2:0] REG_FB_WIDTH  = 3'd1;
  localparam logic [2:0] REG_FB_HEIGHT = 3'd2;
  localparam logic [2:0] REG_FB_PITCH  = 3'd3;
  localparam logic [2:0] REG_FB_BASE   = 3'd4;

  typedef enum logic [1:0] {
    FUNC_FILL   = 2'd0,
    FUNC_DITHER = 2'd1,
    FUNC_GLYPH  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  // framebuffer settings
  typedef struct packed {
    logic        enabled;
    logic [12:0] fb_width;
    logic [12:0] fb_height;
    logic [15:0] fb_pitch;
    logic [31:0] fb_base;
  } cfg_t;

  // one classified row command, only visible columns remain
  typedef struct packed {
    func_t                func;
    logic                 py_odd;
    logic [28:0]          line_off;
    logic [GLYPH_IW-1:0]  x0_lo;
    logic [12:0]          first_px;
    logic [12:0]          last_px;
    logic [GLYPH_W-1:0]   vmask;
    logic [GLYPH_W-1:0]   gbits;
    logic [31:0]          color_a;
    logic [31:0]          color_b;
  } cmd_t;

endpackage

// ===== hw/rtl/clipped_span_pixel_writer_top.sv =====
`timescale 1ns / 1ps

// Row blitter: each input transaction is one fill span, dither span or
// 8-pixel glyph row; each output transaction is one 32-bit pixel write.
// Input side: present the command with push; it is taken when full is low.
// The front clips the row against the framebuffer and queues a command in a
// queue of up to two entries; commands that write nothing are taken and dropped.
// Output side: while empty is low the oldest pixel write is on the out_
// ports; pop takes it. out_last marks the final write of a command.
// Configuration: cfg_ready is always high; cfg_index selects enabled,
// fb_width, fb_height, fb_pitch or fb_base; other indexes are ignored.
// A taken command passes the queue, the command register and the output
// register before its first write appears. Throughput: the back walks the
// visible columns one per cycle while the output advances; the next command
// is loaded only after the last column of the previous one.
// When pop stays low the output register holds and the walk stalls; the
// queue then fills and full rises. Reset clears the configuration registers
// to zero, which leaves the block disabled, and empties queue and output.
module clipped_span_pixel_writer_top #(
  parameter int MAX_SPAN = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic [1:0]          in_func,
  input  logic signed [12:0]  in_x_start,
  input  logic signed [12:0]  in_y_top,
  input  logic [11:0]         in_row_offset,
  input  logic [6:0]          in_span_len,
  input  logic [31:0]         in_color_a,
  input  logic [31:0]         in_color_b,
  input  logic [7:0]          in_glyph_bits,
  input  logic                in_transparent,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [31:0]         out_pixel_addr,
  output logic [31:0]         out_pixel_value,
  output logic                out_last,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import cspw_pkg::*;

  cfg_t  cfg_r;
  logic  in_take;
  logic  cmd_push;
  cmd_t  cmd;
  cmd_t  head_cmd;
  logic  q_full;
  logic  q_empty;
  logic  q_pop;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENABLED:   cfg_r.enabled   <= cfg_data[0];
        REG_FB_WIDTH:  cfg_r.fb_width  <= cfg_data[12:0];
        REG_FB_HEIGHT: cfg_r.fb_height <= cfg_data[12:0];
        REG_FB_PITCH:  cfg_r.fb_pitch  <= cfg_data[15:0];
        REG_FB_BASE:   cfg_r.fb_base   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_full = q_full;
  assign in_take = in_push && !q_full;

  // front: clip and classify
  cspw_front #(
    .MAX_SPAN (MAX_SPAN)
  ) u_front (
    .cfg            (cfg_r),
    .in_take        (in_take),
    .in_func        (in_func),
    .in_x_start     (in_x_start),
    .in_y_top       (in_y_top),
    .in_row_offset  (in_row_offset),
    .in_span_len    (in_span_len),
    .in_color_a     (in_color_a),
    .in_color_b     (in_color_b),
    .in_glyph_bits  (in_glyph_bits),
    .in_transparent (in_transparent),
    .cmd_push       (cmd_push),
    .cmd            (cmd)
  );

  // command queue
  cspw_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  // back: column walk and pixel writes
  cspw_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .fb_base         (cfg_r.fb_base),
    .head_cmd        (head_cmd),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_pixel_addr  (out_pixel_addr),
    .out_pixel_value (out_pixel_value),
    .out_last        (out_last)
  );

endmodule

// ===== hw/rtl/cspw_front.sv =====
`timescale 1ns / 1ps

module cspw_front #(
  parameter int MAX_SPAN = 64
) (
  input  cspw_pkg::cfg_t      cfg,
  input  logic                in_take,
  input  logic [1:0]          in_func,
  input  logic signed [12:0]  in_x_start,
  input  logic signed [12:0]  in_y_top,
  input  logic [11:0]         in_row_offset,
  input  logic [6:0]          in_span_len,
  input  logic [31:0]         in_color_a,
  input  logic [31:0]         in_color_b,
  input  logic [7:0]          in_glyph_bits,
  input  logic                in_transparent,
  output logic                cmd_push,
  output cspw_pkg::cmd_t      cmd
);
  import cspw_pkg::*;

  localparam int CW = $clog2(MAX_SPAN + 1);

  func_t                func;
  logic                 is_glyph;
  logic [CW-1:0]        len_sat;
  logic [CW-1:0]        cnt;
  logic signed [13:0]   py;
  logic                 row_ok;
  logic signed [14:0]   x0s;
  logic signed [14:0]   x_hi;
  logic signed [14:0]   w_hi;
  logic signed [14:0]   lo;
  logic signed [14:0]   hi;
  logic                 span_ok;
  logic [GLYPH_W-1:0]   vm;
  logic [GLYPH_IW-1:0]  gfirst;
  logic [GLYPH_IW-1:0]  glast;
  logic signed [14:0]   gpx_first;
  logic signed [14:0]   gpx_last;

  assign func     = func_t'(in_func);
  assign is_glyph = (func == FUNC_GLYPH);

  // span length, saturated
  assign len_sat = ({25'd0, in_span_len} > MAX_SPAN) ? CW'(MAX_SPAN) : CW'(in_span_len);
  assign cnt     = is_glyph ? CW'(GLYPH_W) : len_sat;

  // pixel row and vertical clip
  assign py     = $signed({in_y_top[12], in_y_top}) + $signed({2'b00, in_row_offset});
  assign row_ok = !py[13] && (py[12:0] < cfg.fb_height);

  // visible column range of the span
  assign x0s     = $signed({{2{in_x_start[12]}}, in_x_start});
  assign x_hi    = x0s + $signed({{(15-CW){1'b0}}, cnt}) - 15'sd1;
  assign w_hi    = $signed({2'b00, cfg.fb_width}) - 15'sd1;
  assign lo      = x0s[14] ? 15'sd0 : x0s;
  assign hi      = (x_hi < w_hi) ? x_hi : w_hi;
  assign span_ok = (cnt != '0) && (lo <= hi);

  // glyph pixels that actually write, and the first and last of them
  always_comb begin
    logic signed [14:0] pxg;
    vm     = '0;
    gfirst = '0;
    glast  = '0;
    for (int i = 0; i < GLYPH_W; i++) begin
      pxg   = x0s + $signed(15'(i));
      vm[i] = (pxg >= lo) && (pxg <= hi) &&
              (in_glyph_bits[GLYPH_W-1-i] || !in_transparent);
    end
    for (int i = GLYPH_W - 1; i >= 0; i--) begin
      if (vm[i]) begin
        gfirst = GLYPH_IW'(i);
      end
    end
    for (int i = 0; i < GLYPH_W; i++) begin
      if (vm[i]) begin
        glast = GLYPH_IW'(i);
      end
    end
  end

  assign gpx_first = x0s + $signed({{(15-GLYPH_IW){1'b0}}, gfirst});
  assign gpx_last  = x0s + $signed({{(15-GLYPH_IW){1'b0}}, glast});

  // drop items that write nothing
  assign cmd_push = in_take && cfg.enabled && (func != FUNC_NONE) && row_ok &&
                    (is_glyph ? (|vm) : span_ok);

  // command payload
  always_comb begin
    cmd.func     = func;
    cmd.py_odd   = py[0];
    cmd.line_off = 29'(py[12:0] * cfg.fb_pitch);
    cmd.x0_lo    = in_x_start[GLYPH_IW-1:0];
    cmd.first_px = is_glyph ? gpx_first[12:0] : lo[12:0];
    cmd.last_px  = is_glyph ? gpx_last[12:0] : hi[12:0];
    cmd.vmask    = vm;
    cmd.gbits    = in_glyph_bits;
    cmd.color_a  = in_color_a;
    cmd.color_b  = in_color_b;
  end

endmodule

// ===== hw/rtl/cspw_cmd_queue.sv =====
`timescale 1ns / 1ps

module cspw_cmd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  cspw_pkg::cmd_t  push_cmd,
  input  logic            pop,
  output cspw_pkg::cmd_t  head_cmd,
  output logic            full,
  output logic            empty
);
  import cspw_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slot_r [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]  count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full     = (count_r == CNTW'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_cmd = slot_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== hw/rtl/cspw_back.sv =====
`timescale 1ns / 1ps

module cspw_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [31:0]     fb_base,
  input  cspw_pkg::cmd_t  head_cmd,
  input  logic            q_empty,
  output logic            q_pop,
  output logic            out_empty,
  input  logic            out_pop,
  output logic [31:0]     out_pixel_addr,
  output logic [31:0]     out_pixel_value,
  output logic            out_last
);
  import cspw_pkg::*;

  logic                 active_r, active_nxt;
  cmd_t                 cmd_r;
  logic [12:0]          px_r;
  logic [31:0]          addr_r;
  logic                 ovalid_r, ovalid_nxt;
  logic [31:0]          oaddr_r;
  logic [31:0]          oval_r;
  logic                 olast_r;
  logic                 out_adv;
  logic                 step;
  logic                 at_end;
  logic [GLYPH_IW-1:0]  gi;
  logic                 vis;
  logic [31:0]          pix_val;

  assign out_adv = !ovalid_r || out_pop;
  assign step    = active_r && out_adv;
  assign at_end  = (px_r == cmd_r.last_px);
  assign q_pop   = !active_r && !q_empty;

  // per pixel visibility and colour
  assign gi = px_r[GLYPH_IW-1:0] - cmd_r.x0_lo;
  always_comb begin
    vis     = 1'b1;
    pix_val = cmd_r.color_a;
    case (cmd_r.func)
      FUNC_FILL: begin
        pix_val = cmd_r.color_a;
      end
      FUNC_DITHER: begin
        pix_val = (px_r[0] ^ cmd_r.py_odd) ? cmd_r.color_a : cmd_r.color_b;
      end
      FUNC_GLYPH: begin
        vis     = cmd_r.vmask[gi];
        pix_val = cmd_r.gbits[GLYPH_W-1-gi] ? cmd_r.color_a : cmd_r.color_b;
      end
      default: begin
        vis = 1'b0;
      end
    endcase
  end

  // busy flag
  always_comb begin
    active_nxt = active_r;
    if (q_pop) begin
      active_nxt = 1'b1;
    end else if (step && at_end) begin
      active_nxt = 1'b0;
    end
  end

  // output register valid
  always_comb begin
    ovalid_nxt = ovalid_r;
    if (out_adv) begin
      ovalid_nxt = step && vis;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // command load and column walk
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r  <= head_cmd;
      px_r   <= head_cmd.first_px;
      addr_r <= fb_base + {3'b000, head_cmd.line_off} + {17'd0, head_cmd.first_px, 2'b00};
    end else if (step) begin
      px_r   <= px_r + 13'd1;
      addr_r <= addr_r + 32'd4;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (step) begin
      oaddr_r <= addr_r;
      oval_r  <= pix_val;
      olast_r <= at_end;
    end
  end

  assign out_empty       = !ovalid_r;
  assign out_pixel_addr  = oaddr_r;
  assign out_pixel_value = oval_r;
  assign out_last        = olast_r;

endmodule
